FILE: src/noisy_sine_test_generator_assert.svh
// Assertion macros for the noisy sine test generator.
// No dependencies; included by the checker module.
`ifndef NOISY_SINE_TEST_GENERATOR_ASSERT_SVH
`define NOISY_SINE_TEST_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled while rst_n is low
`define NSTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while rst_n is low
`define NSTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/nstg_pkg.sv
// Shared types, constants and helper functions of the noisy sine test generator.
// No dependencies.
package nstg_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int NOISE_TERMS_DEF     = 4;
    localparam int QUEUE_DEPTH_DEF     = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVE_ON = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HARMONICS_ON  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED    = 3'd7;

    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    localparam logic signed [31:0] C1 = 32'sd421657428;
    localparam logic signed [31:0] C3 = -32'sd173399667;
    localparam logic signed [31:0] C5 = 32'sd21392326;
    localparam logic signed [31:0] C7 = -32'sd1256749;
    localparam logic signed [31:0] C9 = 32'sd43068;

    localparam int MUL_AW = 32;
    localparam int MUL_BW = 20;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int Y_W    = 24;

    localparam logic signed [MUL_BW-1:0] GAIN_Q16 = 20'sd67502;
    localparam logic signed [MUL_BW-1:0] OFS_Q16  = 20'sd1966;
    localparam logic signed [MUL_AW-1:0] HARM_Q15 = 32'sd3277;

    typedef struct packed {
        logic rec_first;
        logic record_end;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_over;
        logic               record_over;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [31:0]        phase_step;
        logic [15:0]        phase_start;
        logic [15:0]        amplitude;
        logic signed [16:0] dc_offset;
        logic [15:0]        noise_level;
        logic               interleave_on;
        logic               harmonics_on;
    } t_cfg;

    function automatic logic [31:0] lfsr_adv8(input logic [31:0] s);
        logic [31:0] v;
        v = s;
        for (int b = 0; b < 8; b++) begin
            v = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
        end
        return v;
    endfunction

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned rem;
        r   = 0;
        b   = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

endpackage

FILE: src/nstg_front.sv
// Front end: takes input words, tracks phase and parity, draws the noise sum.
// Depends on nstg_pkg.
module nstg_front
    import nstg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int NOISE_TERMS     = NOISE_TERMS_DEF,
    parameter int JOB_W           = 3 + 5 * SINE_TABLE_BITS + 16 + $clog2(NOISE_TERMS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_word         i_in,
    input  t_cfg             i_cfg,
    input  logic             i_seed_load,
    input  logic [31:0]      i_seed,
    output logic             o_push,
    output logic [JOB_W-1:0] o_job,
    input  logic             i_full
);

    localparam int SUM_W = 16 + $clog2(NOISE_TERMS);
    localparam int STEPS = 2 * NOISE_TERMS;
    localparam int CNT_W = $clog2(STEPS);

    typedef struct packed {
        logic                                  start;
        logic                                  last;
        logic                                  odd;
        logic [4:0][SINE_TABLE_BITS-1:0]       phase;
        logic signed [SUM_W-1:0]               sum;
    } t_job;

    logic             r_busy, n_busy;
    logic             r_pend, n_pend;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_acc, n_acc;
    logic             r_odd, n_odd;
    logic [31:0]      r_lfsr, n_lfsr;
    t_job             r_job, n_job;

    logic             accept;
    logic [31:0]      eff_acc;
    logic             eff_odd;
    logic [4:0][31:0] mult_acc;
    logic [15:0]      ph16;
    logic [31:0]      lfsr_nx;

    assign accept  = i_valid && !o_stall;
    assign o_stall = r_busy || !i_rst_n;
    assign o_push  = r_pend && !i_full;
    assign o_job   = r_job;
    assign lfsr_nx = lfsr_adv8(r_lfsr);

    always_comb begin
        eff_acc     = i_in.rec_first ? 32'd0 : r_acc;
        eff_odd     = i_in.rec_first ? 1'b0 : r_odd;
        mult_acc[0] = eff_acc;
        mult_acc[1] = eff_acc << 1;
        mult_acc[2] = eff_acc + (eff_acc << 1);
        mult_acc[3] = eff_acc << 2;
        mult_acc[4] = eff_acc + (eff_acc << 2);
        ph16        = '0;

        n_busy = r_busy;
        n_pend = r_pend;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_odd  = r_odd;
        n_lfsr = r_lfsr;
        n_job  = r_job;

        if (accept) begin
            n_job.start = i_in.rec_first;
            n_job.last  = i_in.record_end;
            n_job.odd   = eff_odd;
            n_job.sum   = '0;
            for (int k = 0; k < 5; k++) begin
                ph16           = mult_acc[k][31:16] + i_cfg.phase_start;
                n_job.phase[k] = ph16[15:16-SINE_TABLE_BITS];
            end
            n_acc  = i_in.record_end ? 32'd0 : eff_acc + i_cfg.phase_step;
            n_odd  = i_in.record_end ? 1'b0 : !eff_odd;
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy && !r_pend) begin
            n_lfsr = lfsr_nx;
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt[0]) begin
                n_job.sum = r_job.sum + SUM_W'($signed(lfsr_nx[15:0]));
            end
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_pend = 1'b1;
            end
        end else if (o_push) begin
            n_pend = 1'b0;
            n_busy = 1'b0;
        end

        if (i_seed_load) begin
            n_lfsr = (i_seed != 32'd0) ? i_seed : 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_odd  <= 1'b0;
            r_lfsr <= 32'd1;
        end else begin
            r_busy <= n_busy;
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_odd  <= n_odd;
            r_lfsr <= n_lfsr;
        end
        r_job <= n_job;
    end

endmodule

FILE: src/nstg_queue.sv
// Small first-in first-out queue between front and back end.
// Depends on nstg_pkg for the default depth.
module nstg_queue
    import nstg_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/nstg_back.sv
// Back end: sine polynomial, noise scaling, mismatch and harmonics on one
// shared multiplier, then overrange and saturation. Depends on nstg_pkg.
module nstg_back
    import nstg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int NOISE_TERMS     = NOISE_TERMS_DEF,
    parameter int JOB_W           = 3 + 5 * SINE_TABLE_BITS + 16 + $clog2(NOISE_TERMS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic [JOB_W-1:0] i_job,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_word        o_out
);

    localparam int SUM_W = 16 + $clog2(NOISE_TERMS);
    localparam int P1_W  = 17 + SUM_W;
    localparam int LO_W  = 38;
    localparam longint unsigned G_ARG = (64'd12 << 32) / NOISE_TERMS;
    localparam logic signed [MUL_BW-1:0] G_Q = MUL_BW'(isqrt(G_ARG));

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SINE_X   = 4'd1;
    localparam logic [3:0] ST_SINE_SQ  = 4'd2;
    localparam logic [3:0] ST_SINE_PLY = 4'd3;
    localparam logic [3:0] ST_SINE_OUT = 4'd4;
    localparam logic [3:0] ST_AMP      = 4'd5;
    localparam logic [3:0] ST_NZ_P1    = 4'd6;
    localparam logic [3:0] ST_NZ_LO    = 4'd7;
    localparam logic [3:0] ST_NZ_HI    = 4'd8;
    localparam logic [3:0] ST_MIS_OFS  = 4'd9;
    localparam logic [3:0] ST_MIS_GAIN = 4'd10;
    localparam logic [3:0] ST_HARM     = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    typedef struct packed {
        logic                                  start;
        logic                                  last;
        logic                                  odd;
        logic [4:0][SINE_TABLE_BITS-1:0]       phase;
        logic signed [SUM_W-1:0]               sum;
    } t_job;

    logic [3:0]              r_state, n_state;
    t_job                    r_job, n_job;
    logic [2:0]              r_sel, n_sel;
    logic [1:0]              r_sub, n_sub;
    logic [15:0]             r_x, n_x;
    logic [15:0]             r_x2, n_x2;
    logic                    r_neg, n_neg;
    logic signed [31:0]      r_a, n_a;
    logic signed [16:0]      r_s, n_s;
    logic signed [Y_W-1:0]   r_y, n_y;
    logic signed [P1_W-1:0]  r_p1, n_p1;
    logic signed [LO_W-1:0]  r_lo, n_lo;
    logic signed [28:0]      r_t, n_t;
    logic                    r_sticky, n_sticky;
    logic                    r_ovalid, n_ovalid;
    t_out_word               r_out, n_out;

    logic signed [MUL_AW-1:0] m_a;
    logic signed [MUL_BW-1:0] m_b;
    logic signed [MUL_PW-1:0] m_p;
    logic [15:0]              q;
    logic [14:0]              rr;
    logic signed [31:0]       coef;
    logic signed [MUL_PW-1:0] s_full;
    logic signed [16:0]       s_val;
    logic signed [63:0]       n_big;
    logic                     over;
    logic                     harm_go;
    logic                     out_free;

    assign o_valid  = r_ovalid;
    assign o_out    = r_out;
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign out_free = !r_ovalid || !i_stall;
    assign harm_go  = i_cfg.harmonics_on;

    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            ST_SINE_SQ: begin
                m_a = MUL_AW'($signed({1'b0, r_x}));
                m_b = MUL_BW'($signed({1'b0, r_x}));
            end
            ST_SINE_PLY: begin
                m_a = r_a;
                m_b = MUL_BW'($signed({1'b0, r_x2}));
            end
            ST_SINE_OUT: begin
                m_a = r_a;
                m_b = MUL_BW'($signed({1'b0, r_x}));
            end
            ST_AMP: begin
                m_a = MUL_AW'($signed({1'b0, i_cfg.amplitude}));
                m_b = MUL_BW'(r_s);
            end
            ST_HARM: begin
                m_a = HARM_Q15;
                m_b = MUL_BW'(r_s);
            end
            ST_NZ_P1: begin
                m_a = MUL_AW'($signed({1'b0, i_cfg.noise_level}));
                m_b = MUL_BW'(r_job.sum);
            end
            ST_NZ_LO: begin
                m_a = MUL_AW'($signed({1'b0, r_p1[17:0]}));
                m_b = G_Q;
            end
            ST_NZ_HI: begin
                m_a = MUL_AW'(r_p1 >>> 18);
                m_b = G_Q;
            end
            ST_MIS_OFS: begin
                m_a = MUL_AW'($signed({1'b0, i_cfg.amplitude}));
                m_b = OFS_Q16;
            end
            ST_MIS_GAIN: begin
                m_a = MUL_AW'(r_y);
                m_b = GAIN_Q16;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_p = MUL_PW'(m_a) * MUL_PW'(m_b);
    end

    always_comb begin
        unique case (r_sub)
            2'd0: coef = C7;
            2'd1: coef = C5;
            2'd2: coef = C3;
            2'd3: coef = C1;
            default: coef = C1;
        endcase
        q      = {r_job.phase[r_sel], {(16 - SINE_TABLE_BITS){1'b0}}};
        rr     = q[14] ? 15'd16384 - {1'b0, q[13:0]} : {1'b0, q[13:0]};
        s_full = m_p >>> 28;
        s_val  = 17'(s_full);
        n_big  = (64'(m_p) <<< 18) + 64'(r_lo);
        over   = (r_y > 32768) || (r_y < -32768);
    end

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_sel    = r_sel;
        n_sub    = r_sub;
        n_x      = r_x;
        n_x2     = r_x2;
        n_neg    = r_neg;
        n_a      = r_a;
        n_s      = r_s;
        n_y      = r_y;
        n_p1     = r_p1;
        n_lo     = r_lo;
        n_t      = r_t;
        n_sticky = r_sticky;
        n_ovalid = (r_ovalid && i_stall);
        n_out    = r_out;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_job   = i_job;
                    n_sel   = 3'd0;
                    n_state = ST_SINE_X;
                    if (n_job.start) begin
                        n_sticky = 1'b0;
                    end
                end
            end
            ST_SINE_X: begin
                n_x     = {rr, 1'b0};
                n_neg   = q[15];
                n_a     = C9;
                n_sub   = 2'd0;
                n_state = ST_SINE_SQ;
            end
            ST_SINE_SQ: begin
                n_x2    = 16'(m_p >>> 15);
                n_state = ST_SINE_PLY;
            end
            ST_SINE_PLY: begin
                n_a   = coef + 32'(m_p >>> 15);
                n_sub = r_sub + 1'b1;
                if (r_sub == 2'd3) begin
                    n_state = ST_SINE_OUT;
                end
            end
            ST_SINE_OUT: begin
                n_s     = r_neg ? -s_val : s_val;
                n_state = (r_sel == 3'd0) ? ST_AMP : ST_HARM;
            end
            ST_AMP: begin
                n_y     = Y_W'(m_p >>> 15);
                n_state = ST_NZ_P1;
            end
            ST_NZ_P1: begin
                n_p1    = P1_W'(m_p);
                n_state = ST_NZ_LO;
            end
            ST_NZ_LO: begin
                n_lo    = LO_W'(m_p);
                n_state = ST_NZ_HI;
            end
            ST_NZ_HI: begin
                n_y = r_y + Y_W'(n_big >>> 32) + Y_W'(i_cfg.dc_offset);
                if (i_cfg.interleave_on && r_job.odd) begin
                    n_state = ST_MIS_OFS;
                end else if (harm_go) begin
                    n_sel   = 3'd1;
                    n_state = ST_SINE_X;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MIS_OFS: begin
                n_t     = 29'(m_p);
                n_state = ST_MIS_GAIN;
            end
            ST_MIS_GAIN: begin
                n_y = Y_W'((m_p + MUL_PW'(r_t)) >>> 16);
                if (harm_go) begin
                    n_sel   = 3'd1;
                    n_state = ST_SINE_X;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_HARM: begin
                n_y = r_y + Y_W'(m_p >>> (5'd16 + {2'b00, r_sel}));
                if (r_sel == 3'd4) begin
                    n_state = ST_DONE;
                end else begin
                    n_sel   = r_sel + 1'b1;
                    n_state = ST_SINE_X;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid          = 1'b1;
                    n_out.sample_over = over;
                    n_out.record_over = r_sticky || over;
                    n_out.last        = r_job.last;
                    if (r_y > 32767) begin
                        n_out.sample = 16'sd32767;
                    end else if (r_y < -32768) begin
                        n_out.sample = -16'sd32768;
                    end else begin
                        n_out.sample = 16'(r_y);
                    end
                    n_sticky = r_job.last ? 1'b0 : (r_sticky || over);
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sticky <= 1'b0;
            r_ovalid <= 1'b0;
            r_sel    <= '0;
            r_sub    <= '0;
        end else begin
            r_state  <= n_state;
            r_sticky <= n_sticky;
            r_ovalid <= n_ovalid;
            r_sel    <= n_sel;
            r_sub    <= n_sub;
        end
        r_job <= n_job;
        r_x   <= n_x;
        r_x2  <= n_x2;
        r_neg <= n_neg;
        r_a   <= n_a;
        r_s   <= n_s;
        r_y   <= n_y;
        r_p1  <= n_p1;
        r_lo  <= n_lo;
        r_t   <= n_t;
        r_out <= n_out;
    end

endmodule

FILE: src/noisy_sine_test_generator.sv
// Channel   | valid    | stall    | word
// ----------+----------+----------+---------------------------------------
// input     | i_valid  | o_stall  | i_in  : rec_first, record_end
// output    | o_valid  | i_stall  | o_out : sample, sample_over, record_over, last
// config    | i_cfg_we | -        | i_cfg_idx, i_cfg_data
//
// Front end draws the noise sum for each word from the noise LFSR (8 steps a cycle while drawing).
// Back end works each word through its single shared multiplier, with extra steps for mismatch
// and for harmonics; it takes a new word only when idle, and that multiplier sets the sustained rate.
// Reset is synchronous, active low; the LFSR restarts from the default seed of one.
// Stalls on either side are absorbed by a two-word queue and the output register.
// Top level; depends on nstg_pkg, nstg_front, nstg_queue and nstg_back.
module noisy_sine_test_generator
    import nstg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int NOISE_TERMS     = NOISE_TERMS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int JOB_W = 3 + 5 * SINE_TABLE_BITS + 16 + $clog2(NOISE_TERMS);

    t_cfg        r_cfg, n_cfg;
    logic [31:0] r_seed, n_seed;
    logic        seed_load;

    logic             push, pop, full, empty;
    logic [JOB_W-1:0] job_in, job_out;

    assign seed_load = i_cfg_we && (i_cfg_idx == REG_NOISE_SEED);

    always_comb begin
        n_cfg  = r_cfg;
        n_seed = r_seed;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PHASE_STEP:    n_cfg.phase_step    = i_cfg_data;
                REG_PHASE_START:   n_cfg.phase_start   = i_cfg_data[15:0];
                REG_AMPLITUDE:     n_cfg.amplitude     = i_cfg_data[15:0];
                REG_DC_OFFSET:     n_cfg.dc_offset     = i_cfg_data[16:0];
                REG_NOISE_LEVEL:   n_cfg.noise_level   = i_cfg_data[15:0];
                REG_INTERLEAVE_ON: n_cfg.interleave_on = i_cfg_data[0];
                REG_HARMONICS_ON:  n_cfg.harmonics_on  = i_cfg_data[0];
                REG_NOISE_SEED:    n_seed              = i_cfg_data;
                default:           n_seed              = r_seed;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step    <= '0;
            r_cfg.phase_start   <= '0;
            r_cfg.amplitude     <= 16'd32768;
            r_cfg.dc_offset     <= '0;
            r_cfg.noise_level   <= 16'd3277;
            r_cfg.interleave_on <= 1'b0;
            r_cfg.harmonics_on  <= 1'b0;
            r_seed              <= 32'd1;
        end else begin
            r_cfg  <= n_cfg;
            r_seed <= n_seed;
        end
    end

    nstg_front #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .NOISE_TERMS     (NOISE_TERMS),
        .JOB_W           (JOB_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .i_seed_load (seed_load),
        .i_seed      (i_cfg_data),
        .o_push      (push),
        .o_job       (job_in),
        .i_full      (full)
    );

    nstg_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    nstg_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .NOISE_TERMS     (NOISE_TERMS),
        .JOB_W           (JOB_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_job   (job_out),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

endmodule

FILE: src/nstg_checker.sv
// Port-level checks on the generator output, bound to the top level.
// Depends on nstg_pkg and noisy_sine_test_generator_assert.svh.
`include "noisy_sine_test_generator_assert.svh"

module nstg_checker
    import nstg_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_out
);

    `NSTG_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out), "stalled output word changed")
    `NSTG_ASSERT_NXT(a_rst_idle, i_clk, 1'b1, !i_rst_n, !o_valid, "output valid right after reset")
    `NSTG_ASSERT_IMP(a_sticky, i_clk, i_rst_n, o_valid && o_out.sample_over, o_out.record_over, "overrange word without record flag")
    `NSTG_ASSERT_IMP(a_sat, i_clk, i_rst_n, o_valid && o_out.sample_over, (o_out.sample == 16'sd32767) || (o_out.sample == -16'sd32768), "overrange word not saturated")

endmodule

bind noisy_sine_test_generator nstg_checker u_nstg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
